FILE: rtl/core/crlf_pkg.sv
// Shared types, constants and the control program of the comb reverb.
`default_nettype none

package crlf_pkg;

    // Delay line and word widths.
    localparam int DELAY_LEN = 1600;
    localparam int POS_W     = $clog2(DELAY_LEN + 1);
    localparam int ADDR_W    = (DELAY_LEN > 1) ? $clog2(DELAY_LEN) : 1;
    localparam int SAMPLE_W  = 16;
    localparam int LEVEL_W   = 5;

    // Filter arithmetic: inputs hold sample*scale, outputs are Q16.24 in 40 bits.
    localparam int XI_W       = 31;
    localparam int Y_W        = 40;
    localparam int FRAC_W     = 24;
    localparam int COEF_SPLIT = 12;
    localparam int SUM_W      = 43;

    // Shared multiplier and accumulator.
    localparam int MA_W   = 29;
    localparam int MB_W   = 26;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 13;

    // Truncating divide by twenty: floor(m/20) = (floor(m/4) * RECIP) >> 22.
    localparam int MIX_W     = 23;
    localparam int DMAG_W    = MIX_W - 2;
    localparam int DIV_SHIFT = 22;
    localparam int QUOT_W    = 21;

    localparam logic signed [MB_W-1:0] K_IN_SCALE = MB_W'(28888);
    localparam logic signed [MB_W-1:0] K_COEF_Y0  = MB_W'(-14866750);
    localparam logic signed [MB_W-1:0] K_COEF_Y1  = MB_W'(31528413);
    localparam logic signed [MB_W-1:0] K_TWENTY   = MB_W'(20);
    localparam logic signed [MB_W-1:0] K_RECIP    = MB_W'(838861);

    // Multiplier operand selects.
    typedef enum logic [2:0] {
        MA_DELAYED = 3'd0,
        MA_YO0_HI  = 3'd1,
        MA_YO0_LO  = 3'd2,
        MA_YO1_HI  = 3'd3,
        MA_YO1_LO  = 3'd4,
        MA_FILT    = 3'd5,
        MA_SAMPLE  = 3'd6,
        MA_DMAG    = 3'd7
    } t_mul_a;

    typedef enum logic [2:0] {
        MB_SCALE  = 3'd0,
        MB_C0     = 3'd1,
        MB_C1     = 3'd2,
        MB_LEVEL  = 3'd3,
        MB_TWENTY = 3'd4,
        MB_RECIP  = 3'd5
    } t_mul_b;

    typedef enum logic [1:0] {
        ACC_HOLD    = 2'd0,
        ACC_LOAD    = 2'd1,
        ACC_LOAD_SH = 2'd2,
        ACC_ADD     = 2'd3
    } t_acc_op;

    typedef enum logic [2:0] {
        SUM_HOLD      = 3'd0,
        SUM_LOAD_P    = 3'd1,
        SUM_ADD_COEF  = 3'd2,
        SUM_ADD_XI0   = 3'd3,
        SUM_ADD_XI1X2 = 3'd4
    } t_sum_op;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_READ    = 3'd1,
        ACT_UPDATE  = 3'd2,
        ACT_FILT    = 3'd3,
        ACT_DIVPREP = 3'd4,
        ACT_WRITE   = 3'd5
    } t_act;

    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_WAIT_IN  = 3'd1,
        COND_IF_FILL  = 3'd2,
        COND_JUMP     = 3'd3,
        COND_WAIT_OUT = 3'd4
    } t_cond;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_mul_a  mul_a;
        t_mul_b  mul_b;
        t_acc_op acc_op;
        t_sum_op sum_op;
        t_act    act;
        t_cond   cond;
        t_step   target;
    } t_ctrl;

    // Program addresses.
    localparam t_step ST_FETCH    = 5'd0;
    localparam t_step ST_READ     = 5'd1;
    localparam t_step ST_XMUL     = 5'd2;
    localparam t_step ST_C0_HI    = 5'd3;
    localparam t_step ST_C0_LO    = 5'd4;
    localparam t_step ST_C1_HI    = 5'd5;
    localparam t_step ST_C1_LO    = 5'd6;
    localparam t_step ST_C1_ACC   = 5'd7;
    localparam t_step ST_C1_SUM   = 5'd8;
    localparam t_step ST_ADD_XI0  = 5'd9;
    localparam t_step ST_ADD_XI1  = 5'd10;
    localparam t_step ST_UPDATE   = 5'd11;
    localparam t_step ST_FILT     = 5'd12;
    localparam t_step ST_FB_MUL   = 5'd13;
    localparam t_step ST_DRY_MUL  = 5'd14;
    localparam t_step ST_MIX      = 5'd15;
    localparam t_step ST_DIV_PREP = 5'd16;
    localparam t_step ST_DIV_MUL  = 5'd17;
    localparam t_step ST_WRITE    = 5'd18;
    localparam t_step ST_OUT      = 5'd19;
    localparam t_step ST_FILL     = 5'd20;
    localparam t_step ST_FILL_ACC = 5'd21;

    // Control store. The product of a step is registered and is consumed by a later step.
    function automatic t_ctrl ucode(input t_step s);
        t_ctrl c;
        c = '{mul_a: MA_SAMPLE, mul_b: MB_LEVEL, acc_op: ACC_HOLD, sum_op: SUM_HOLD,
              act: ACT_NONE, cond: COND_NEXT, target: ST_FETCH};
        case (s)
            ST_FETCH:    c.cond = COND_WAIT_IN;
            ST_READ: begin
                c.act    = ACT_READ;
                c.cond   = COND_IF_FILL;
                c.target = ST_FILL;
            end
            ST_XMUL: begin
                c.mul_a = MA_DELAYED;
                c.mul_b = MB_SCALE;
            end
            ST_C0_HI: begin
                c.sum_op = SUM_LOAD_P;
                c.mul_a  = MA_YO0_HI;
                c.mul_b  = MB_C0;
            end
            ST_C0_LO: begin
                c.acc_op = ACC_LOAD_SH;
                c.mul_a  = MA_YO0_LO;
                c.mul_b  = MB_C0;
            end
            ST_C1_HI: begin
                c.acc_op = ACC_ADD;
                c.mul_a  = MA_YO1_HI;
                c.mul_b  = MB_C1;
            end
            ST_C1_LO: begin
                c.sum_op = SUM_ADD_COEF;
                c.acc_op = ACC_LOAD_SH;
                c.mul_a  = MA_YO1_LO;
                c.mul_b  = MB_C1;
            end
            ST_C1_ACC:   c.acc_op = ACC_ADD;
            ST_C1_SUM:   c.sum_op = SUM_ADD_COEF;
            ST_ADD_XI0:  c.sum_op = SUM_ADD_XI0;
            ST_ADD_XI1:  c.sum_op = SUM_ADD_XI1X2;
            ST_UPDATE:   c.act = ACT_UPDATE;
            ST_FILT:     c.act = ACT_FILT;
            ST_FB_MUL: begin
                c.mul_a = MA_FILT;
                c.mul_b = MB_LEVEL;
            end
            ST_DRY_MUL: begin
                c.acc_op = ACC_LOAD;
                c.mul_a  = MA_SAMPLE;
                c.mul_b  = MB_TWENTY;
            end
            ST_MIX:      c.acc_op = ACC_ADD;
            ST_DIV_PREP: c.act = ACT_DIVPREP;
            ST_DIV_MUL: begin
                c.mul_a = MA_DMAG;
                c.mul_b = MB_RECIP;
            end
            ST_WRITE:    c.act = ACT_WRITE;
            ST_OUT: begin
                c.cond   = COND_WAIT_OUT;
                c.target = ST_FETCH;
            end
            ST_FILL: begin
                c.mul_a = MA_SAMPLE;
                c.mul_b = MB_LEVEL;
            end
            ST_FILL_ACC: begin
                c.acc_op = ACC_LOAD;
                c.cond   = COND_JUMP;
                c.target = ST_DIV_PREP;
            end
            default: begin
                c.cond   = COND_JUMP;
                c.target = ST_FETCH;
            end
        endcase
        return c;
    endfunction

    // Clamp to the 16-bit sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [20:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 21'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -21'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/crlf_if.sv
// Word channels of the comb reverb: sample in and sample out.
`default_nettype none

interface crlf_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [crlf_pkg::SAMPLE_W-1:0]   in_sample;
    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

interface crlf_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [crlf_pkg::SAMPLE_W-1:0]   out_sample;
    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/crlf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module crlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/crlf_seq.sv
// Step counter and control store of the comb reverb sequencer.
`default_nettype none

module crlf_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_fire,
    input  wire logic           i_running,
    input  wire logic           i_out_free,
    output crlf_pkg::t_ctrl     o_ctrl
);
    import crlf_pkg::*;

    t_step r_step;
    t_step n_step;

    assign o_ctrl = ucode(r_step);

    always_comb begin
        case (o_ctrl.cond)
            COND_NEXT:     n_step = r_step + 1'b1;
            COND_WAIT_IN:  n_step = i_in_fire ? r_step + 1'b1 : r_step;
            COND_IF_FILL:  n_step = i_running ? r_step + 1'b1 : o_ctrl.target;
            COND_JUMP:     n_step = o_ctrl.target;
            COND_WAIT_OUT: n_step = i_out_free ? o_ctrl.target : r_step;
            default:       n_step = ST_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/comb_reverb_lowpass_feedback.sv
// Feedback comb reverb with a second-order lowpass in the loop, microcoded datapath.
//
//   channel   dir  handshake      word
//   i_in      in   valid/ready    in_sample, signed 16 bits
//   o_out     out  valid/ready    out_sample, signed 16 bits
//   i_cfg_*   in   write enable   decay_level, 5 bits
//
// A word passes through more control steps while the reverb runs than during the first
// DELAY_LEN words; the sequencer walks one control word per cycle, unless it waits for
// an input or an output word, through a single shared 29x26 multiplier.
// The output register holds a finished word, so the next word is accepted while it waits;
// only a second finished word stalls the sequencer until the first is taken.
// Reset clears the slot position, the fill flag, the filter history and decay_level.
// The delay line is not cleared: every slot is written during the fill phase.
`default_nettype none

module comb_reverb_lowpass_feedback (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [crlf_pkg::LEVEL_W-1:0]   i_cfg_data,
    crlf_in_if.sink                             i_in,
    crlf_out_if.source                          o_out
);
    import crlf_pkg::*;

    t_ctrl ctrl;
    logic  in_fire;
    logic  out_free;

    logic [LEVEL_W-1:0]             r_level;
    logic [POS_W-1:0]               r_pos;
    logic                           r_running;
    logic signed [SAMPLE_W-1:0]     r_sample;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [SUM_W-1:0]        r_sum;
    logic signed [XI_W-1:0]         r_xnew;
    logic signed [XI_W-1:0]         r_xi0;
    logic signed [XI_W-1:0]         r_xi1;
    logic signed [Y_W-1:0]          r_yo0;
    logic signed [Y_W-1:0]          r_yo1;
    logic signed [SAMPLE_W-1:0]     r_filt;
    logic                           r_neg;
    logic [DMAG_W-1:0]              r_dmag;
    logic                           r_out_valid;
    logic signed [SAMPLE_W-1:0]     r_out_data;

    logic [SAMPLE_W-1:0]            ram_rdata;
    logic signed [SAMPLE_W-1:0]     wdata;
    logic signed [MA_W-1:0]         mul_a;
    logic signed [MB_W-1:0]         mul_b;
    logic signed [Y_W-1:0]          y_sat;
    logic signed [Y_W:0]            y_adj;
    logic signed [MIX_W-1:0]        mix;
    logic [MIX_W-1:0]               mix_mag;
    logic [QUOT_W-1:0]              quot;
    logic signed [20:0]             quot_s;
    logic signed [SAMPLE_W:0]       wet_sum;
    logic signed [SAMPLE_W-1:0]     out_val;

    crlf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_running  (r_running),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    crlf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DELAY_LEN)
    ) u_delay (
        .i_clk   (i_clk),
        .i_we    (ctrl.act == ACT_WRITE),
        .i_waddr (r_pos[ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_re    (ctrl.act == ACT_READ),
        .i_raddr (r_pos[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // No word is taken while reset is held.
    assign i_in.ready       = (ctrl.cond == COND_WAIT_IN) && i_rst_n;
    assign in_fire          = i_in.valid && i_in.ready;
    assign out_free         = !r_out_valid || o_out.ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.out_sample = r_out_data;

    always_comb begin
        case (ctrl.mul_a)
            MA_DELAYED: mul_a = MA_W'($signed(ram_rdata));
            MA_YO0_HI:  mul_a = MA_W'($signed(r_yo0[Y_W-1:COEF_SPLIT]));
            MA_YO0_LO:  mul_a = $signed({{(MA_W-COEF_SPLIT){1'b0}}, r_yo0[COEF_SPLIT-1:0]});
            MA_YO1_HI:  mul_a = MA_W'($signed(r_yo1[Y_W-1:COEF_SPLIT]));
            MA_YO1_LO:  mul_a = $signed({{(MA_W-COEF_SPLIT){1'b0}}, r_yo1[COEF_SPLIT-1:0]});
            MA_FILT:    mul_a = MA_W'(r_filt);
            MA_SAMPLE:  mul_a = MA_W'(r_sample);
            MA_DMAG:    mul_a = $signed({{(MA_W-DMAG_W){1'b0}}, r_dmag});
            default:    mul_a = '0;
        endcase
    end

    always_comb begin
        case (ctrl.mul_b)
            MB_SCALE:  mul_b = K_IN_SCALE;
            MB_C0:     mul_b = K_COEF_Y0;
            MB_C1:     mul_b = K_COEF_Y1;
            MB_LEVEL:  mul_b = $signed({{(MB_W-LEVEL_W){1'b0}}, r_level});
            MB_TWENTY: mul_b = K_TWENTY;
            MB_RECIP:  mul_b = K_RECIP;
            default:   mul_b = '0;
        endcase
    end

    // New filter output, clamped to the 40-bit Q16.24 range.
    always_comb begin
        if (r_sum[SUM_W-1:Y_W-1] == '0 || r_sum[SUM_W-1:Y_W-1] == '1) begin
            y_sat = r_sum[Y_W-1:0];
        end else if (r_sum[SUM_W-1]) begin
            y_sat = {1'b1, {(Y_W-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(Y_W-1){1'b1}}};
        end
    end

    // Biasing a negative value by one below the LSB weight makes the shift truncate toward zero.
    assign y_adj = (Y_W + 1)'(r_yo1)
                 + (r_yo1[Y_W-1] ? (Y_W + 1)'((1 << FRAC_W) - 1) : (Y_W + 1)'(0));

    assign mix     = r_acc[MIX_W-1:0];
    assign mix_mag = r_acc[ACC_W-1] ? MIX_W'(-mix) : MIX_W'(mix);
    assign quot    = r_prod[DIV_SHIFT+QUOT_W-1:DIV_SHIFT];
    assign quot_s  = r_neg ? -$signed(quot) : $signed(quot);
    assign wdata   = sat_sample(quot_s);
    assign wet_sum = (SAMPLE_W + 1)'(r_sample) + (SAMPLE_W + 1)'(r_filt);
    assign out_val = r_running ? sat_sample(21'(wet_sum)) : r_sample;

    // Control and model state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_pos       <= '0;
            r_running   <= 1'b0;
            r_xi0       <= '0;
            r_xi1       <= '0;
            r_yo0       <= '0;
            r_yo1       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_level <= i_cfg_data;
            end
            // The slot position wraps when the next word arrives, which also ends the fill.
            if (in_fire && r_pos >= POS_W'(DELAY_LEN)) begin
                r_pos     <= '0;
                r_running <= 1'b1;
            end else if (ctrl.act == ACT_WRITE) begin
                r_pos <= r_pos + 1'b1;
            end
            if (ctrl.act == ACT_UPDATE) begin
                r_xi0 <= r_xi1;
                r_xi1 <= r_xnew;
                r_yo0 <= r_yo1;
                r_yo1 <= y_sat;
            end
            if (ctrl.cond == COND_WAIT_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath words.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample <= i_in.in_sample;
        end
        r_prod <= mul_a * mul_b;
        case (ctrl.acc_op)
            ACC_LOAD:    r_acc <= ACC_W'(r_prod);
            ACC_LOAD_SH: r_acc <= ACC_W'(r_prod) <<< COEF_SPLIT;
            ACC_ADD:     r_acc <= r_acc + ACC_W'(r_prod);
            default:     r_acc <= r_acc;
        endcase
        case (ctrl.sum_op)
            SUM_LOAD_P: begin
                r_sum  <= SUM_W'(r_prod);
                r_xnew <= r_prod[XI_W-1:0];
            end
            SUM_ADD_COEF:  r_sum <= r_sum + $signed(r_acc[SUM_W+FRAC_W-1:FRAC_W]);
            SUM_ADD_XI0:   r_sum <= r_sum + SUM_W'(r_xi0);
            SUM_ADD_XI1X2: r_sum <= r_sum + (SUM_W'(r_xi1) <<< 1);
            default:       r_sum <= r_sum;
        endcase
        if (ctrl.act == ACT_FILT) begin
            r_filt <= y_adj[Y_W-1:FRAC_W];
        end
        if (ctrl.act == ACT_DIVPREP) begin
            r_neg  <= r_acc[ACC_W-1];
            r_dmag <= mix_mag[MIX_W-1:2];
        end
        if (ctrl.cond == COND_WAIT_OUT && out_free) begin
            r_out_data <= out_val;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(DELAY_LEN))
        else $error("slot position beyond the delay length");

    a_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.act == ACT_WRITE) |-> (r_pos < POS_W'(DELAY_LEN)))
        else $error("delay line written outside its slots");

    a_running_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |=> r_running)
        else $error("reverb left the running phase without reset");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (ctrl.act == ACT_READ))
        else $error("accepted word not followed by a delay read");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(ctrl.cond == COND_WAIT_OUT))
        else $error("output word raised outside the output step");

endmodule

`default_nettype wire

FILE: dv/tb_comb_reverb_lowpass_feedback.sv
// Self-checking testbench of the comb reverb with its lowpass feedback loop.
`default_nettype none

class reverb_scoreboard;
    localparam longint IN_SCALE_Q24 = 28888;
    localparam longint A2_Q24       = -14866750;
    localparam longint A1_Q24       = 31528413;
    localparam longint Y_MAX        = (longint'(1) <<< 39) - 1;
    localparam longint Y_MIN        = -(longint'(1) <<< 39);

    logic signed [crlf_pkg::SAMPLE_W-1:0] delay_slots [crlf_pkg::DELAY_LEN];
    logic [crlf_pkg::POS_W-1:0]           slot_pos;
    bit                                   wet;
    logic signed [crlf_pkg::XI_W-1:0]     x_hist [2];
    logic signed [crlf_pkg::Y_W-1:0]      y_hist [2];
    logic [crlf_pkg::LEVEL_W-1:0]         decay_level;
    logic signed [crlf_pkg::SAMPLE_W-1:0] expected_samples [$];
    int                                   mismatches;
    int                                   checked;
    int                                   wet_words;

    function new();
        slot_pos    = '0;
        wet         = 1'b0;
        x_hist[0]   = '0;
        x_hist[1]   = '0;
        y_hist[0]   = '0;
        y_hist[1]   = '0;
        decay_level = '0;
        mismatches  = 0;
        checked     = 0;
        wet_words   = 0;
    endfunction

    function void set_level(input logic [crlf_pkg::LEVEL_W-1:0] lvl);
        decay_level = lvl;
    endfunction

    function int outstanding();
        return expected_samples.size();
    endfunction

    function logic signed [crlf_pkg::SAMPLE_W-1:0] clamp16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // floor(y * c / 2^24), split so that no partial product overflows.
    function longint feedback_term(input longint y, input longint c);
        longint hi;
        longint lo;
        longint part;
        hi   = y >>> 12;
        lo   = y - hi * 4096;
        part = (lo * c) >>> 12;
        return (hi * c + part) >>> 12;
    endfunction

    function void note_input(input logic signed [crlf_pkg::SAMPLE_W-1:0] s);
        longint smp;
        longint lvl;
        longint delayed;
        longint x_new;
        longint y_new;
        longint filt;
        logic signed [crlf_pkg::SAMPLE_W-1:0] result;
        smp = s;
        lvl = decay_level;
        if (slot_pos >= crlf_pkg::DELAY_LEN) begin
            wet      = 1'b1;
            slot_pos = '0;
        end
        if (wet) begin
            delayed = delay_slots[slot_pos];
            x_new   = delayed * IN_SCALE_Q24;
            y_new   = longint'(x_hist[0]) + x_new + 2 * longint'(x_hist[1])
                    + feedback_term(longint'(y_hist[0]), A2_Q24)
                    + feedback_term(longint'(y_hist[1]), A1_Q24);
            if (y_new > Y_MAX) y_new = Y_MAX;
            if (y_new < Y_MIN) y_new = Y_MIN;
            x_hist[0] = x_hist[1];
            x_hist[1] = x_new[crlf_pkg::XI_W-1:0];
            y_hist[0] = y_hist[1];
            y_hist[1] = y_new[crlf_pkg::Y_W-1:0];
            // The filter output drops its fraction toward zero, not toward minus infinity.
            filt = (y_new >= 0) ? (y_new >>> 24) : -((-y_new) >>> 24);
            delay_slots[slot_pos] = clamp16((20 * smp + filt * lvl) / 20);
            result = clamp16(smp + filt);
            wet_words++;
        end else begin
            delay_slots[slot_pos] = clamp16((smp * lvl) / 20);
            result = s;
        end
        slot_pos++;
        expected_samples.push_back(result);
    endfunction

    function void check_output(input logic signed [crlf_pkg::SAMPLE_W-1:0] got);
        logic signed [crlf_pkg::SAMPLE_W-1:0] want;
        if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected output word %0d with nothing pending", got);
            end
            return;
        end
        want = expected_samples.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("out_sample mismatch at word %0d: expected %0d, got %0d",
                         checked, want, got);
            end
        end
        checked++;
    endfunction
endclass

module tb_comb_reverb_lowpass_feedback;
    import crlf_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int NUM_EDGES   = 16;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [LEVEL_W-1:0]  i_cfg_data;
    int                  recv_stall_pct;
    int                  cycle_count;
    reverb_scoreboard    sb;

    logic signed [SAMPLE_W-1:0] edge_samples [NUM_EDGES] = '{
        16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'shFFFE,
        16'sh5555, 16'shAAAA, 16'sh7FFE, 16'sh8001, 16'sd21, -16'sd21,
        16'sd19, -16'sd19, 16'sd20, -16'sd20
    };

    crlf_in_if  in_ch ();
    crlf_out_if out_ch ();

    comb_reverb_lowpass_feedback u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("run stopped by the cycle limit with %0d words pending", sb.outstanding());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            out_ch.ready = (int'($urandom_range(99)) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_input(in_ch.in_sample);
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_output(out_ch.out_sample);
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic signed [SAMPLE_W-1:0] s;
        // One word in eight is 7FFF, 8000, 0 or -1, so that saturation gets exercised.
        if ($urandom_range(7) == 0) begin
            s = edge_samples[$urandom_range(3)];
        end else begin
            s = SAMPLE_W'($urandom_range(16'hFFFF));
        end
        return s;
    endfunction

    task automatic write_level(input logic [LEVEL_W-1:0] lvl);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = lvl;
        sb.set_level(lvl);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input int idle_pct);
        while (int'($urandom_range(99)) < idle_pct) begin
            in_ch.valid     = 1'b0;
            in_ch.in_sample = SAMPLE_W'($urandom_range(16'hFFFF));
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.in_sample = s;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic play_phase(input logic [LEVEL_W-1:0] lvl, input int send_idle,
                              input int recv_idle, input int count, input bit use_edges);
        wait_drained();
        write_level(lvl);
        recv_stall_pct = recv_idle;
        for (int i = 0; i < count; i++) begin
            send_sample(use_edges ? edge_samples[i % NUM_EDGES] : random_sample(), send_idle);
        end
        in_ch.valid = 1'b0;
    endtask

    initial begin
        sb              = new();
        recv_stall_pct  = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.in_sample = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill phase: the first DELAY_LEN words pass straight through.
        play_phase(5'd31, 0, 0, NUM_EDGES, 1'b1);
        play_phase(5'd0, 72, 0, 396, 1'b0);
        play_phase(5'd16, 0, 72, 396, 1'b0);
        play_phase(5'd1, 28, 28, 396, 1'b0);
        play_phase(5'($urandom_range(31)), 0, 0, 396, 1'b0);

        // The delay line is full now, so every further word goes through the lowpass loop.
        play_phase(5'd31, 0, 0, NUM_EDGES, 1'b1);
        play_phase(5'd16, 72, 0, 60, 1'b0);
        play_phase(5'd0, 0, 72, 60, 1'b0);
        play_phase(5'd31, 28, 28, 60, 1'b0);
        play_phase(5'($urandom_range(31)), 0, 0, 60, 1'b0);

        wait_drained();
        $display("checked %0d output words, %0d of them from the lowpass feedback loop",
                 sb.checked, sb.wet_words);
        $display("decay levels 0, 1, 16, 31 and random ones, with and without stalls");
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: comb_reverb_lowpass_feedback.f
rtl/core/crlf_pkg.sv
rtl/core/crlf_if.sv
rtl/core/crlf_ram.sv
rtl/core/crlf_seq.sv
rtl/core/comb_reverb_lowpass_feedback.sv
dv/tb_comb_reverb_lowpass_feedback.sv
